// ----- hw/rtl/sshs_pkg.sv -----
package sshs_pkg;

   // channel widths
   localparam int ReqDataW = 16;
   localparam int RspDataW = 32;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 16;

   // register indexes on the csr port
   localparam logic [CsrIdxW-1:0] CSR_STEP_INTERVAL = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_SETTLE        = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_MIN_ECHO      = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_MAX_ECHO      = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_CRUISE        = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_REACT         = 3'd5;

   // microcode program counter
   localparam int PcW = 4;
   typedef logic [PcW-1:0] pc_type;

   localparam pc_type PC_FETCH = 4'd0;
   localparam pc_type PC_SEQ   = 4'd1;
   localparam pc_type PC_TEST  = 4'd2;
   localparam pc_type PC_PINIT = 4'd3;
   localparam pc_type PC_PREAD = 4'd4;
   localparam pc_type PC_PACC  = 4'd5;
   localparam pc_type PC_PEND  = 4'd6;
   localparam pc_type PC_STORE = 4'd7;
   localparam pc_type PC_DRIVE = 4'd8;
   localparam pc_type PC_EMIT  = 4'd9;

   // datapath operation of one step
   typedef enum logic [3:0] {
      OP_FETCH,
      OP_SEQ,
      OP_NOP,
      OP_PINIT,
      OP_PREAD,
      OP_PACC,
      OP_PEND,
      OP_STORE,
      OP_DRIVE,
      OP_EMIT
   } op_type;

   // how the step counter moves on
   typedef enum logic [2:0] {
      BR_NEXT,
      BR_WAIT_IN,
      BR_NO_PICK,
      BR_MORE,
      BR_WAIT_OUT
   } br_type;

   typedef struct packed {
      op_type op;
      br_type br;
      pc_type target;
   } uword_type;

   // datapath flags seen by the sequencer
   typedef struct packed {
      logic pick;
      logic more;
      logic out_free;
   } dp_stat_type;

endpackage

// ----- hw/rtl/sshs_ucode_rom.sv -----
module sshs_ucode_rom (
   input  sshs_pkg::pc_type    pc,
   output sshs_pkg::uword_type uw
);
   import sshs_pkg::*;

   // one control word per program step
   always_comb begin
      case (pc)
         PC_FETCH: uw = '{op: OP_FETCH, br: BR_WAIT_IN,  target: PC_FETCH};
         PC_SEQ:   uw = '{op: OP_SEQ,   br: BR_NEXT,     target: PC_FETCH};
         PC_TEST:  uw = '{op: OP_NOP,   br: BR_NO_PICK,  target: PC_STORE};
         PC_PINIT: uw = '{op: OP_PINIT, br: BR_NEXT,     target: PC_FETCH};
         PC_PREAD: uw = '{op: OP_PREAD, br: BR_NEXT,     target: PC_FETCH};
         PC_PACC:  uw = '{op: OP_PACC,  br: BR_MORE,     target: PC_PREAD};
         PC_PEND:  uw = '{op: OP_PEND,  br: BR_NEXT,     target: PC_FETCH};
         PC_STORE: uw = '{op: OP_STORE, br: BR_NEXT,     target: PC_FETCH};
         PC_DRIVE: uw = '{op: OP_DRIVE, br: BR_NEXT,     target: PC_FETCH};
         PC_EMIT:  uw = '{op: OP_EMIT,  br: BR_WAIT_OUT, target: PC_FETCH};
         default:  uw = '{op: OP_NOP,   br: BR_WAIT_OUT, target: PC_FETCH};
      endcase
   end

endmodule

// ----- hw/rtl/sshs_datapath.sv -----
module sshs_datapath #(
   parameter int NUM_ANGLES = 7,
   parameter int STEP_DEG   = 15
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sshs_pkg::uword_type           uw,
   input  logic                          req_tvalid,
   input  logic [sshs_pkg::ReqDataW-1:0] req_tdata,
   input  logic                          req_tuser,
   input  logic                          rsp_tready,
   output logic                          rsp_tvalid,
   output logic [sshs_pkg::RspDataW-1:0] rsp_tdata,
   input  logic                          csr_we,
   input  logic [sshs_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [sshs_pkg::CsrDataW-1:0] csr_wdata,
   output sshs_pkg::dp_stat_type         stat
);
   import sshs_pkg::*;

   localparam int IW      = $clog2(NUM_ANGLES);
   localparam int AW      = IW + 6;
   localparam int OFF_MAX = (NUM_ANGLES - 1) * STEP_DEG;
   localparam int OW      = $clog2(2 * OFF_MAX + 256) + 1;
   localparam int SW      = 18;

   localparam logic [IW-1:0] LAST_IDX  = IW'(NUM_ANGLES - 1);
   localparam logic [IW-1:0] MID_IDX   = IW'(NUM_ANGLES / 2);
   localparam logic [IW:0]   LAST_WIDE = (IW + 1)'(NUM_ANGLES - 1);
   localparam logic [AW-1:0] SERVO_MAX = AW'(180);

   localparam logic [1:0] PH_STEP   = 2'd0;
   localparam logic [1:0] PH_SETTLE = 2'd1;
   localparam logic [1:0] PH_ECHO   = 2'd2;

   // configuration
   logic [15:0] step_int_ff, settle_ff, min_echo_ff, max_echo_ff;
   logic [7:0]  cruise_ff;
   logic [6:0]  react_ff;

   // latched beat
   logic        kind_ff, kind_in;
   logic [15:0] echo_ff, echo_in;

   // sweep sequencer state
   logic [31:0]   now_ff, now_in, last_ff, last_in, move_ff, move_in;
   logic [1:0]    phase_ff, phase_in;
   logic [IW-1:0] scan_ff, scan_in, sample_ff, sample_in, heading_ff, heading_in;
   logic          down_ff, down_in, trig_ff, trig_in, pick_ff, pick_in;
   logic [7:0]    servo_ff, servo_in;

   // heading search
   logic [IW-1:0] k_ff, k_in, bi_ff, bi_in;
   logic [15:0]   w1_ff, w1_in, w2_ff, w2_in;
   logic [SW-1:0] best_ff, best_in;
   logic          found_ff, found_in;

   // steering results
   logic [7:0] speed_ff, speed_in;
   logic [6:0] dir_ff, dir_in, hdeg_ff, hdeg_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RspDataW-1:0] rsp_data_ff, rsp_data_in;

   // echo store with per-entry valid bits
   logic [15:0] mem [NUM_ANGLES];
   logic        vld_ff [NUM_ANGLES];
   logic [15:0] rd_data_ff;
   logic        rd_vld_ff;
   logic        mem_we;
   logic [15:0] mem_wdata;

   // combinational helpers
   logic [31:0]          base, diff, limit;
   logic                 ge;
   logic [IW:0]          sc;
   logic [AW-1:0]        sprod, hprod;
   logic [15:0]          rd_val;
   logic [SW-1:0]        sum;
   logic signed [OW-1:0] o2, o2r, half, thr, offv, noff;
   logic [OW-1:0]        mag, cru;
   logic                 steer;
   logic                 out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign stat.pick     = pick_ff;
   assign stat.more     = (k_ff != LAST_IDX);
   assign stat.out_free = out_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // elapsed time against the limit of the current phase
   assign base  = (phase_ff == PH_SETTLE) ? move_ff : last_ff;
   assign limit = (phase_ff == PH_SETTLE) ? {16'd0, settle_ff} : {16'd0, step_int_ff};
   assign diff  = now_ff - base;
   assign ge    = (diff >= limit);

   // next scan position in the sweep
   always_comb begin
      if (down_ff) begin
         sc = (scan_ff != '0) ? ({1'b0, scan_ff} - 1'b1) : {1'b0, scan_ff};
      end else begin
         sc = {1'b0, scan_ff} + 1'b1;
      end
   end

   assign sprod = AW'(scan_ff) * AW'(STEP_DEG);

   // box sum over the current entry and the two before it
   assign rd_val = rd_vld_ff ? rd_data_ff : 16'd0;
   assign sum    = SW'(rd_val) + SW'(w1_ff) + SW'(w2_ff);

   // steering offset in half degrees, then truncated to degrees
   assign hprod = AW'(heading_ff) * AW'(STEP_DEG);
   assign o2    = OW'({hprod, 1'b0}) - OW'(OFF_MAX);
   assign thr   = OW'({react_ff, 1'b0});
   assign steer = (o2 > thr) || (o2 < -thr);
   assign o2r   = o2 + $signed({{(OW - 1){1'b0}}, o2[OW-1]});
   assign half  = o2r >>> 1;
   assign offv  = steer ? half : '0;
   assign noff  = -offv;
   assign mag   = offv[OW-1] ? noff : offv;
   assign cru   = OW'(cruise_ff);

   // microcode step execution
   always_comb begin
      kind_in      = kind_ff;
      echo_in      = echo_ff;
      now_in       = now_ff;
      last_in      = last_ff;
      move_in      = move_ff;
      phase_in     = phase_ff;
      scan_in      = scan_ff;
      sample_in    = sample_ff;
      heading_in   = heading_ff;
      down_in      = down_ff;
      trig_in      = trig_ff;
      pick_in      = pick_ff;
      servo_in     = servo_ff;
      k_in         = k_ff;
      bi_in        = bi_ff;
      w1_in        = w1_ff;
      w2_in        = w2_ff;
      best_in      = best_ff;
      found_in     = found_ff;
      speed_in     = speed_ff;
      dir_in       = dir_ff;
      hdeg_in      = hdeg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_wdata    = ((echo_ff < max_echo_ff) && (echo_ff > min_echo_ff)) ? echo_ff : 16'd0;

      case (uw.op)
         OP_FETCH: begin
            if (req_tvalid) begin
               kind_in = req_tuser;
               echo_in = req_tdata;
               if (!req_tuser) begin
                  now_in = now_ff + 32'd1;
               end
            end
         end
         OP_SEQ: begin
            trig_in = 1'b0;
            pick_in = 1'b0;
            case (phase_ff)
               PH_STEP: begin
                  if (ge) begin
                     last_in   = now_ff;
                     move_in   = now_ff;
                     pick_in   = (scan_ff == '0) || (scan_ff == LAST_IDX);
                     sample_in = scan_ff;
                     servo_in  = (sprod > SERVO_MAX) ? 8'd180 : sprod[7:0];
                     phase_in  = PH_SETTLE;
                  end
               end
               PH_SETTLE: begin
                  if (ge) begin
                     trig_in  = 1'b1;
                     phase_in = PH_ECHO;
                     scan_in  = sc[IW-1:0];
                     if (sc >= LAST_WIDE) begin
                        scan_in = LAST_IDX;
                        down_in = 1'b1;
                     end else if (sc == '0) begin
                        down_in = 1'b0;
                     end
                  end
               end
               default: begin
                  if (kind_ff || (diff > limit)) begin
                     phase_in = PH_STEP;
                  end
               end
            endcase
         end
         OP_PINIT: begin
            k_in     = '0;
            bi_in    = '0;
            w1_in    = 16'd0;
            w2_in    = 16'd0;
            best_in  = '0;
            found_in = 1'b0;
         end
         OP_PACC: begin
            if (k_ff == '0) begin
               best_in = sum;
            end else if (sum > best_ff) begin
               best_in  = sum;
               bi_in    = k_ff;
               found_in = 1'b1;
            end
            w2_in = w1_ff;
            w1_in = rd_val;
            k_in  = k_ff + 1'b1;
         end
         OP_PEND: begin
            heading_in = found_ff ? bi_ff : MID_IDX;
         end
         OP_STORE: begin
            mem_we = kind_ff;
         end
         OP_DRIVE: begin
            hdeg_in = hprod[6:0];
            dir_in  = noff[6:0];
            if (offv == '0) begin
               speed_in = cruise_ff;
            end else if ({1'b0, cru} >= {mag, 1'b0}) begin
               speed_in = 8'd255;
            end else if (cru >= mag) begin
               speed_in = 8'd200;
            end else begin
               speed_in = 8'd0;
            end
         end
         OP_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {dir_ff, speed_ff, hdeg_ff, phase_ff, trig_ff, servo_ff[6:0]};
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff       <= '0;
         last_ff      <= '0;
         move_ff      <= '0;
         phase_ff     <= PH_STEP;
         scan_ff      <= '0;
         sample_ff    <= '0;
         heading_ff   <= '0;
         down_ff      <= 1'b0;
         trig_ff      <= 1'b0;
         pick_ff      <= 1'b0;
         servo_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         now_ff       <= now_in;
         last_ff      <= last_in;
         move_ff      <= move_in;
         phase_ff     <= phase_in;
         scan_ff      <= scan_in;
         sample_ff    <= sample_in;
         heading_ff   <= heading_in;
         down_ff      <= down_in;
         trig_ff      <= trig_in;
         pick_ff      <= pick_in;
         servo_ff     <= servo_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and search working registers
   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      echo_ff     <= echo_in;
      k_ff        <= k_in;
      bi_ff       <= bi_in;
      w1_ff       <= w1_in;
      w2_ff       <= w2_in;
      best_ff     <= best_in;
      found_ff    <= found_in;
      speed_ff    <= speed_in;
      dir_ff      <= dir_in;
      hdeg_ff     <= hdeg_in;
      rsp_data_ff <= rsp_data_in;
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         step_int_ff <= 16'd200;
         settle_ff   <= 16'd100;
         min_echo_ff <= 16'd100;
         max_echo_ff <= 16'd20000;
         cruise_ff   <= 8'd120;
         react_ff    <= 7'd10;
      end else if (csr_we) begin
         case (csr_index)
            CSR_STEP_INTERVAL: step_int_ff <= csr_wdata;
            CSR_SETTLE:        settle_ff   <= csr_wdata;
            CSR_MIN_ECHO:      min_echo_ff <= csr_wdata;
            CSR_MAX_ECHO:      max_echo_ff <= csr_wdata;
            CSR_CRUISE:        cruise_ff   <= csr_wdata[7:0];
            CSR_REACT:         react_ff    <= csr_wdata[6:0];
            default: begin
            end
         endcase
      end
   end

   // echo store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[sample_ff] <= mem_wdata;
      end
      if (uw.op == OP_PREAD) begin
         rd_data_ff <= mem[k_ff];
      end
   end

   // entry valid bits, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_ANGLES; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (mem_we) begin
         vld_ff[sample_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (uw.op == OP_PREAD) begin
         rd_vld_ff <= vld_ff[k_ff];
      end
   end

endmodule

// ----- hw/rtl/sonar_sweep_heading_selector.sv -----
// channel | dir | beat contents
// req     | in  | tdata: echo_us[15:0]; tuser: kind
// rsp     | out | tdata: servo_angle, trigger, phase, heading_deg, drive_speed, jet_dir
// csr     | in  | csr_we, csr_index, csr_wdata; no read-back
//
// one beat at a time under a microcode program; a step at a sweep end also
// runs the heading search, which reads the echo store entries one at a time,
// each with a read step and then an accumulate step.
// reset is synchronous, req_tready low meanwhile; echo store cleared by valid bits.
// a result held in the output register does not stop the next req beat;
// the emit step of that beat waits until the held result is taken.
module sonar_sweep_heading_selector #(
   parameter int NUM_ANGLES = 7,
   parameter int STEP_DEG   = 15
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [sshs_pkg::ReqDataW-1:0] req_tdata,  // echo_us
   input  logic                          req_tuser,  // kind
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // servo_angle[6:0], trigger[7], phase[9:8], heading_deg[16:10],
   // drive_speed[24:17], jet_dir[31:25]
   output logic [sshs_pkg::RspDataW-1:0] rsp_tdata,
   input  logic                          csr_we,
   input  logic [sshs_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [sshs_pkg::CsrDataW-1:0] csr_wdata
);
   import sshs_pkg::*;

   pc_type      pc_ff, pc_in;
   uword_type   uw;
   dp_stat_type stat;

   sshs_ucode_rom u_rom (
      .pc (pc_ff),
      .uw (uw)
   );

   sshs_datapath #(
      .NUM_ANGLES (NUM_ANGLES),
      .STEP_DEG   (STEP_DEG)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .uw         (uw),
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .stat       (stat)
   );

   assign req_tready = (uw.op == OP_FETCH) && !reset;

   // step counter with conditional jumps
   always_comb begin
      case (uw.br)
         BR_WAIT_IN:  pc_in = req_tvalid ? pc_ff + 1'b1 : pc_ff;
         BR_NO_PICK:  pc_in = stat.pick ? pc_ff + 1'b1 : uw.target;
         BR_MORE:     pc_in = stat.more ? uw.target : pc_ff + 1'b1;
         BR_WAIT_OUT: pc_in = stat.out_free ? uw.target : pc_ff;
         default:     pc_in = pc_ff + 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_FETCH;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// ----- sim/sonar_sweep_heading_selector_test.sv -----
module sonar_sweep_heading_selector_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_ANGLES = 7;
   localparam int STEP_DEG   = 15;

   typedef enum logic [1:0] {
      STEP_WAIT   = 2'd0,
      SETTLE_PING = 2'd1,
      AWAIT_ECHO  = 2'd2
   } sweep_phase_type;

   typedef enum logic {
      KIND_TICK = 1'b0,
      KIND_ECHO = 1'b1
   } beat_kind_type;

   typedef struct {
      logic [6:0]        servo_angle;
      logic              trigger;
      sweep_phase_type   phase;
      logic [6:0]        heading_deg;
      logic [7:0]        drive_speed;
      logic signed [6:0] jet_dir;
   } heading_result_type;

   // sweep sequencer and heading predictor plus the queue of expected results
   class heading_scoreboard;
      logic [15:0]        interval_ms, settle_ms, min_us, max_us;
      logic [7:0]         cruise;
      logic [6:0]         react;
      logic [31:0]        ms_count, step_mark, move_mark;
      sweep_phase_type    seq;
      int unsigned        scan_idx, sample_idx;
      bit                 descending;
      int unsigned        widths [NUM_ANGLES];
      int unsigned        head_idx;
      logic [6:0]         servo_deg;
      heading_result_type pending [$];
      int                 errors;

      function new();
         interval_ms = 16'd200;
         settle_ms   = 16'd100;
         min_us      = 16'd100;
         max_us      = 16'd20000;
         cruise      = 8'd120;
         react       = 7'd10;
         ms_count    = '0;
         step_mark   = '0;
         move_mark   = '0;
         seq         = STEP_WAIT;
         scan_idx    = 0;
         sample_idx  = 0;
         descending  = 1'b0;
         foreach (widths[k]) widths[k] = 0;
         head_idx    = 0;
         servo_deg   = '0;
         errors      = 0;
      endfunction

      function void set_reg(logic [sshs_pkg::CsrIdxW-1:0] idx, logic [15:0] value);
         case (idx)
            sshs_pkg::CSR_STEP_INTERVAL: interval_ms = value;
            sshs_pkg::CSR_SETTLE:        settle_ms   = value;
            sshs_pkg::CSR_MIN_ECHO:      min_us      = value;
            sshs_pkg::CSR_MAX_ECHO:      max_us      = value;
            sshs_pkg::CSR_CRUISE:        cruise      = value[7:0];
            sshs_pkg::CSR_REACT:         react       = value[6:0];
            default: ;
         endcase
      endfunction

      // causal three-tap sum, strict argmax, middle angle when nothing beats entry 0
      function void pick_heading();
         int unsigned sums [NUM_ANGLES];
         int unsigned best, idx;
         bit          found;
         found = 1'b0;
         idx   = 0;
         for (int k = 0; k < NUM_ANGLES; k++) begin
            sums[k] = widths[k];
            if (k >= 1) sums[k] += widths[k-1];
            if (k >= 2) sums[k] += widths[k-2];
         end
         best = sums[0];
         for (int k = 0; k < NUM_ANGLES; k++) begin
            if (sums[k] > best) begin
               best  = sums[k];
               idx   = k;
               found = 1'b1;
            end
         end
         head_idx = found ? idx : NUM_ANGLES / 2;
      endfunction

      function void note_input(beat_kind_type kind, logic [15:0] echo_us);
         logic [31:0]        since_step, since_move;
         int unsigned        ang;
         int                 hdeg, o2, off, mag, speed;
         heading_result_type exp;
         exp.trigger = 1'b0;
         if (kind == KIND_TICK) ms_count++;
         since_step = ms_count - step_mark;
         since_move = ms_count - move_mark;

         // one pass of the sequencer
         case (seq)
            STEP_WAIT: begin
               if (since_step >= interval_ms) begin
                  step_mark = ms_count;
                  if (scan_idx == 0 || scan_idx >= NUM_ANGLES - 1) pick_heading();
                  sample_idx = scan_idx;
                  ang        = scan_idx * STEP_DEG;
                  servo_deg  = 7'((ang > 180) ? 180 : ang);
                  move_mark  = ms_count;
                  seq        = SETTLE_PING;
               end
            end
            SETTLE_PING: begin
               if (since_move >= settle_ms) begin
                  exp.trigger = 1'b1;
                  if (descending) begin
                     if (scan_idx > 0) scan_idx--;
                  end else begin
                     scan_idx++;
                  end
                  if (scan_idx >= NUM_ANGLES - 1) begin
                     scan_idx   = NUM_ANGLES - 1;
                     descending = 1'b1;
                  end else if (scan_idx == 0) begin
                     descending = 1'b0;
                  end
                  seq = AWAIT_ECHO;
               end
            end
            default: begin
               if (kind == KIND_ECHO || since_step > interval_ms) seq = STEP_WAIT;
            end
         endcase

         // echo width is stored last, zero outside the open window
         if (kind == KIND_ECHO && sample_idx < NUM_ANGLES)
            widths[sample_idx] = (echo_us < max_us && echo_us > min_us) ? echo_us : 0;

         // steering and speed from the current heading
         hdeg = head_idx * STEP_DEG;
         o2   = 2 * hdeg - (NUM_ANGLES - 1) * STEP_DEG;
         off  = 0;
         if (o2 > 2 * int'(react) || o2 < -2 * int'(react)) off = o2 / 2;
         if (off != 0) begin
            mag   = (off < 0) ? -off : off;
            speed = 200 * (int'(cruise) / mag);
            if (speed > 255) speed = 255;
         end else begin
            speed = cruise;
         end

         exp.servo_angle = servo_deg;
         exp.phase       = seq;
         exp.heading_deg = 7'(hdeg);
         exp.drive_speed = 8'(speed);
         exp.jet_dir     = 7'(-off);
         pending.push_back(exp);
      endfunction

      function void compare(string name, int want, int got);
         if (want != got) begin
            errors++;
            if (errors <= 50)
               $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_result(logic [sshs_pkg::RspDataW-1:0] data);
         heading_result_type exp;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 50)
               $display("%0t unexpected result beat: expected none, actual %h", $time, data);
            return;
         end
         exp = pending.pop_front();
         compare("servo_angle", exp.servo_angle, data[6:0]);
         compare("trigger", exp.trigger, data[7]);
         compare("phase", exp.phase, data[9:8]);
         compare("heading_deg", exp.heading_deg, data[16:10]);
         compare("drive_speed", exp.drive_speed, data[24:17]);
         compare("jet_dir", int'(exp.jet_dir), int'($signed(data[31:25])));
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          req_tvalid;
   logic                          req_tready;
   logic [sshs_pkg::ReqDataW-1:0] req_tdata;   // echo_us
   logic                          req_tuser;   // kind
   logic                          rsp_tvalid;
   logic                          rsp_tready;
   // servo_angle, trigger, phase, heading_deg, drive_speed, jet_dir
   logic [sshs_pkg::RspDataW-1:0] rsp_tdata;
   logic                          csr_we;
   logic [sshs_pkg::CsrIdxW-1:0]  csr_index;
   logic [sshs_pkg::CsrDataW-1:0] csr_wdata;

   heading_scoreboard board;
   int send_calm  = 0;
   int ready_calm = 0;
   int ready_hold = 0;

   sonar_sweep_heading_selector #(
      .NUM_ANGLES(NUM_ANGLES),
      .STEP_DEG  (STEP_DEG)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   // receiver back-pressure: short stalls, a few long ones, calm stretches
   always @(posedge clock) begin
      int r;
      if (ready_calm > 0) begin
         ready_calm--;
         rsp_tready <= 1'b1;
      end else if (ready_hold > 0) begin
         ready_hold--;
         rsp_tready <= 1'b0;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 5) ready_calm = $urandom_range(20, 200);
         else if (r < 8) ready_hold = $urandom_range(15, 50);
         else if (r < 40) ready_hold = $urandom_range(1, 3);
         rsp_tready <= (ready_hold == 0);
      end
   end

   // result beats go to the scoreboard
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_tvalid === 1'b1 && rsp_tready === 1'b1)
         board.check_result(rsp_tdata);
   end

   function automatic int next_gap();
      int r;
      if (send_calm > 0) begin
         send_calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) send_calm = $urandom_range(20, 80);
      if (r < 60) return 0;
      if (r < 96) return $urandom_range(1, 4);
      return $urandom_range(15, 50);
   endfunction

   // widths around the window edges, the field extremes and inside the window
   function automatic logic [15:0] pick_width();
      int lo, hi;
      lo = board.min_us;
      hi = board.max_us;
      case ($urandom_range(0, 11))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'(lo);
         3: return 16'(lo + 1);
         4: return 16'(hi);
         5: return 16'(hi - 1);
         6: return 16'($urandom);
         default: begin
            if (hi > lo + 1) return 16'($urandom_range(lo + 1, hi - 1));
            return 16'($urandom);
         end
      endcase
   endfunction

   task automatic send_beat(beat_kind_type kind, logic [15:0] echo_us);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= echo_us;
      do @(posedge clock); while (req_tready !== 1'b1);
      board.note_input(kind, echo_us);
      gap = next_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_reg(logic [sshs_pkg::CsrIdxW-1:0] idx, int value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 16'(value);
      @(posedge clock);
      board.set_reg(idx, 16'(value));
   endtask

   task automatic apply_settings(int step_ms, int settle, int lo, int hi, int cruise,
                                 int react);
      write_reg(sshs_pkg::CSR_STEP_INTERVAL, step_ms);
      write_reg(sshs_pkg::CSR_SETTLE, settle);
      write_reg(sshs_pkg::CSR_MIN_ECHO, lo);
      write_reg(sshs_pkg::CSR_MAX_ECHO, hi);
      write_reg(sshs_pkg::CSR_CRUISE, cruise);
      write_reg(sshs_pkg::CSR_REACT, react);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // mostly echoes while one is awaited, otherwise ticks, with stray echoes
   task automatic run_sweeps(int count);
      int            r;
      beat_kind_type kind;
      repeat (count) begin
         r = $urandom_range(0, 99);
         if ((board.seq == AWAIT_ECHO && r < 55) || r < 4) kind = KIND_ECHO;
         else kind = KIND_TICK;
         send_beat(kind, (kind == KIND_ECHO) ? pick_width() : 16'($urandom));
      end
   endtask

   // wait for every expected beat, then let the block settle
   task automatic drain();
      int waited;
      waited = 0;
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      if (board.pending.size() != 0) begin
         board.errors++;
         $display("%0t results stalled: expected %0d more, actual 0", $time,
                  board.pending.size());
      end
      repeat (30) @(posedge clock);
   endtask

   initial begin
      int lo, hi;
      board = new();
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= 1'b0;
      csr_we     <= 1'b0;
      csr_index  <= '0;
      csr_wdata  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: stray echoes at the window edges and field extremes
      send_beat(KIND_ECHO, 16'd0);
      send_beat(KIND_ECHO, 16'hFFFF);
      send_beat(KIND_ECHO, 16'd100);
      send_beat(KIND_ECHO, 16'd101);
      send_beat(KIND_ECHO, 16'd19999);
      send_beat(KIND_ECHO, 16'd20000);
      send_beat(KIND_ECHO, 16'h5555);
      send_beat(KIND_TICK, 16'hFFFF);
      send_beat(KIND_TICK, 16'h0000);
      send_beat(KIND_ECHO, 16'h2AAA);
      send_beat(KIND_TICK, 16'h1234);
      drain();

      // fixed settings, the extremes, then random ones
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: apply_settings(3, 1, 100, 20000, 120, 10);
            1: apply_settings(1, 0, 0, 65535, 255, 0);
            2: apply_settings(65535, 65535, 65535, 0, 0, 90);
            default: begin
               lo = $urandom_range(0, 3000);
               hi = $urandom_range(lo, 65535);
               apply_settings($urandom_range(1, 8), $urandom_range(0, 5), lo, hi,
                              $urandom_range(0, 255), $urandom_range(0, 90));
            end
         endcase
         run_sweeps((ph == 2) ? 25 : 200);
         drain();
      end

      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // overall watchdog
   initial begin
      #4ms;
      $display("TB_ERROR");
      $finish;
   end
endmodule
